[hw/rtl/lslag_pkg.sv]
// ----------------------------------------------------------------------------
// lslag_pkg
// Shared types, constants and table functions for the lux and auto-gain core.
// ----------------------------------------------------------------------------
`default_nettype none

package lslag_pkg;

  localparam int unsigned CH_W   = 16;
  localparam int unsigned NUM_W  = 52;  // lux numerator, Q.40 scaled
  localparam int unsigned DIVN_W = 37;  // divider dividend / quotient
  localparam int unsigned DIVD_W = 23;  // divider divisor
  localparam int unsigned MULX_W = 21;
  localparam int unsigned MULY_W = 18;
  localparam int unsigned MULP_W = MULX_W + MULY_W;

  localparam logic [CH_W-1:0] SAT_SHORT  = 16'd36863;
  localparam logic [CH_W-1:0] SAT_LONG   = 16'd65535;
  localparam logic [CH_W-1:0] LOW_SIGNAL = 16'd100;

  localparam logic [2:0] CODE_MAX = 3'd5;
  localparam logic [1:0] GAIN_MAX = 2'd3;
  localparam logic [1:0] GAIN_RST = 2'd1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RETRY = 2'd1;
  localparam logic [1:0] ST_SAT   = 2'd2;

  typedef enum logic [1:0] {
    SEG_ONE   = 2'd0,
    SEG_TWO   = 2'd1,
    SEG_THREE = 2'd2,
    SEG_FOUR  = 2'd3
  } lslag_seg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SEG,
    S_DIVR,
    S_DIVR_W,
    S_ROM,
    S_MUL_BP,
    S_SUB1,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_A,
    S_MUL_B,
    S_SUB2,
    S_SCALE,
    S_DIVQ,
    S_DIVQ_W,
    S_DONE
  } lslag_state_t;

  // Q0.24 coefficients
  function automatic logic [MULX_W-1:0] coef_a(input lslag_seg_t seg);
    logic [MULX_W-1:0] c;
    unique case (seg)
      SEG_ONE:   c = 21'd510027;
      SEG_TWO:   c = 21'd375810;
      SEG_THREE: c = 21'd214748;
      SEG_FOUR:  c = 21'd24495;
      default:   c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [MULX_W-1:0] coef_b(input lslag_seg_t seg);
    logic [MULX_W-1:0] c;
    unique case (seg)
      SEG_ONE:   c = 21'd1040187;
      SEG_TWO:   c = 21'd520094;
      SEG_THREE: c = 21'd256691;
      SEG_FOUR:  c = 21'd18790;
      default:   c = '0;
    endcase
    return c;
  endfunction

  // 100 * (code + 1) * gain factor
  function automatic logic [DIVD_W-1:0] den_of(input logic [2:0] code,
                                                input logic [1:0] gain);
    logic [DIVD_W-1:0] t;
    logic [DIVD_W-1:0] f;
    t = DIVD_W'(100) * DIVD_W'({1'b0, code} + 4'd1);
    unique case (gain)
      2'd0:    f = DIVD_W'(1);
      2'd1:    f = DIVD_W'(25);
      2'd2:    f = DIVD_W'(400);
      2'd3:    f = DIVD_W'(9900);
      default: f = '0;
    endcase
    return DIVD_W'(t * f);
  endfunction

  // (i / 2^bits)^1.4 in Q0.16, from a truncated fifth root in Q0.12
  function automatic logic [15:0] pow_entry(input int idx, input int bits);
    longint unsigned target;
    longint unsigned y;
    longint unsigned cand;
    longint unsigned p5;
    longint unsigned ii;
    ii = longint'(idx);
    target = (ii * ii) << (60 - 2 * bits);
    y = 0;
    for (int b = 12; b >= 0; b--) begin
      cand = y | (longint'(1) << b);
      if (cand <= 4096) begin
        p5 = cand * cand * cand * cand * cand;
        if (p5 <= target) begin
          y = cand;
        end
      end
    end
    return 16'((ii * y * 16) >> bits);
  endfunction

endpackage

`default_nettype wire

[hw/rtl/lslag_if.sv]
// ----------------------------------------------------------------------------
// lslag_if
// Valid/ready channels of the lux core: reading in, result out, config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface lslag_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] full_spectrum_count;
  logic [15:0] infrared_count;
  modport source (output valid, full_spectrum_count, infrared_count, input ready);
  modport sink   (input valid, full_spectrum_count, infrared_count, output ready);
endinterface

interface lslag_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] lux_value;
  logic [1:0]  gain_used;
  logic [1:0]  gain_next;
  modport source (output valid, status, lux_value, gain_used, gain_next, input ready);
  modport sink   (input valid, status, lux_value, gain_used, gain_next, output ready);
endinterface

interface lslag_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] integration_code;
  modport source (output valid, integration_code, input ready);
  modport sink   (input valid, integration_code, output ready);
endinterface

`default_nettype wire

[hw/rtl/lslag_div.sv]
// ----------------------------------------------------------------------------
// lslag_div
// Restoring divider, one quotient bit per cycle, shared by the ratio and lux.
// ----------------------------------------------------------------------------
`default_nettype none

module lslag_div
  import lslag_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIVN_W-1:0] num,
  input  wire logic [DIVD_W-1:0] den,
  output logic                   done,
  output logic [DIVN_W-1:0]      quo
);

  localparam int unsigned CNT_W = $clog2(DIVN_W + 1);

  logic              run_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVD_W-1:0] den_r;
  logic [DIVD_W-1:0] rem_r;
  logic [DIVN_W-1:0] quo_r;
  logic [DIVD_W:0]   rem_sh;
  logic [DIVD_W:0]   rem_sub;
  logic              ge;

  assign rem_sh  = {rem_r, quo_r[DIVN_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(DIVN_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= '0;
      quo_r <= num;
    end else if (run_r) begin
      rem_r <= ge ? rem_sub[DIVD_W-1:0] : rem_sh[DIVD_W-1:0];
      quo_r <= {quo_r[DIVN_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

  a_done_after_run : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(run_r) && !run_r)
    else $error("divider done without a run");

  a_no_restart : assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !run_r)
    else $error("divider started while busy");

  a_idle_count : assert property (@(posedge clk) disable iff (!rst_n)
    !run_r |-> cnt_r == '0 || $past(start) == 1'b0 && cnt_r == '0)
    else $error("divider count left over");

endmodule

`default_nettype wire

[hw/rtl/light_sensor_lux_autogain_core.sv]
// ----------------------------------------------------------------------------
// light_sensor_lux_autogain_core
// Lux from a two-channel light reading, with a four-level automatic gain.
// ----------------------------------------------------------------------------
// One reading is taken at a time. A saturated reading above the lowest gain
// or a zero full-spectrum count goes straight to the result. The three upper
// ratio segments use the divider at most once, for the final lux scaling; the
// lowest segment uses it for the channel ratio and then, unless the lux comes
// out zero, for the final lux scaling. The restoring divider yields one
// quotient bit per cycle over 37 bits. A finished result sits in the output
// register while the next reading is taken in. Lux is unsigned Q16.16 and the
// power term comes from a 2^POW_TABLE_BITS entry ROM with a registered read.
`default_nettype none

module light_sensor_lux_autogain_core
  import lslag_pkg::*;
#(
  parameter int POW_TABLE_BITS = 10
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lslag_in_if.sink    in_bus,
  lslag_out_if.source out_bus,
  lslag_cfg_if.sink   cfg_bus
);

  localparam int unsigned ROM_DEPTH = 2 ** POW_TABLE_BITS;

  lslag_state_t state_r, state_nxt;

  logic [2:0]        code_cfg_r;
  logic [1:0]        gain_r;
  logic [CH_W-1:0]   ch0_r;
  logic [CH_W-1:0]   ch1_r;
  logic [2:0]        code_r;
  logic [1:0]        used_r;
  logic [1:0]        status_r;
  lslag_seg_t        seg_r;
  logic [31:0]       lux_r;
  logic [MULP_W-1:0] prod_r;
  logic [MULP_W-1:0] pos_r;
  logic [35:0]       t_r;
  logic [NUM_W-1:0]  acc_r;
  logic [DIVN_W-1:0] div_num_r;
  logic [DIVD_W-1:0] div_den_r;
  logic [POW_TABLE_BITS-1:0] idx_r;
  logic [15:0]       rom_q_r;

  logic              out_valid_r;
  logic [1:0]        o_status_r;
  logic [31:0]       o_lux_r;
  logic [1:0]        o_used_r;
  logic [1:0]        o_next_r;

  logic [15:0]       pow_rom [ROM_DEPTH];

  logic              in_fire;
  logic [2:0]        code_in;
  logic [CH_W-1:0]   limit;
  logic              sat;
  logic              retry;
  logic [1:0]        gain_new;
  logic              div_start;
  logic              div_done;
  logic [DIVN_W-1:0] div_quo;
  logic [MULX_W-1:0] mul_x;
  logic [MULY_W-1:0] mul_y;
  logic [MULP_W-1:0] mul_p;
  logic [MULP_W-1:0] pos1;
  logic [MULP_W-1:0] diff2;
  logic [60:0]       scaled;
  logic              emit;

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    assign pow_rom[g] = pow_entry(g, POW_TABLE_BITS);
  end

  assign in_bus.ready  = (state_r == S_IDLE);
  assign cfg_bus.ready = 1'b1;
  assign in_fire       = in_bus.valid && in_bus.ready;

  // codes six and seven behave as 100 ms
  assign code_in = (code_cfg_r > CODE_MAX) ? 3'd0 : code_cfg_r;
  assign limit   = (code_in == 3'd0) ? SAT_SHORT : SAT_LONG;
  assign sat     = (in_bus.full_spectrum_count >= limit) ||
                   (in_bus.infrared_count >= limit);
  assign retry   = sat && (gain_r != 2'd0);

  always_comb begin
    gain_new = gain_r;
    if (retry) begin
      gain_new = gain_r - 2'd1;
    end else if (in_bus.full_spectrum_count < LOW_SIGNAL && gain_r < GAIN_MAX) begin
      gain_new = gain_r + 2'd1;
    end
  end

  // shared multiplier
  always_comb begin
    mul_x = '0;
    mul_y = '0;
    unique case (state_r)
      S_MUL_BP: begin
        mul_x = coef_b(SEG_ONE);
        mul_y = {2'b0, rom_q_r};
      end
      S_MUL_LO: begin
        mul_x = {5'b0, ch0_r};
        mul_y = t_r[17:0];
      end
      S_MUL_HI: begin
        mul_x = {5'b0, ch0_r};
        mul_y = t_r[35:18];
      end
      S_MUL_A: begin
        mul_x = coef_a(seg_r);
        mul_y = {2'b0, ch0_r};
      end
      S_MUL_B: begin
        mul_x = coef_b(seg_r);
        mul_y = {2'b0, ch1_r};
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign mul_p  = MULP_W'(mul_x) * MULP_W'(mul_y);
  assign pos1   = MULP_W'(coef_a(SEG_ONE)) << 16;
  assign diff2  = pos_r - prod_r;
  // 408 = 256 + 128 + 16 + 8
  assign scaled = ({9'b0, acc_r} << 8) + ({9'b0, acc_r} << 7) +
                  ({9'b0, acc_r} << 4) + ({9'b0, acc_r} << 3);
  assign div_start = (state_r == S_DIVR) || (state_r == S_DIVQ);
  assign emit      = (state_r == S_DONE) && (!out_valid_r || out_bus.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = (retry || in_bus.full_spectrum_count == '0) ? S_DONE : S_SEG;
        end
      end
      S_SEG: begin
        if ({1'b0, ch1_r, 1'b0} <= {2'b0, ch0_r}) begin
          state_nxt = S_DIVR;
        end else if ((23'd100 * {7'b0, ch1_r} <= 23'd61 * {7'b0, ch0_r}) ||
                     (19'd5 * {3'b0, ch1_r} <= 19'd4 * {3'b0, ch0_r}) ||
                     (20'd10 * {4'b0, ch1_r} <= 20'd13 * {4'b0, ch0_r})) begin
          state_nxt = S_MUL_A;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DIVR:   state_nxt = S_DIVR_W;
      S_DIVR_W: if (div_done) state_nxt = S_ROM;
      S_ROM:    state_nxt = S_MUL_BP;
      S_MUL_BP: state_nxt = S_SUB1;
      S_SUB1:   state_nxt = (prod_r >= pos1) ? S_DONE : S_MUL_LO;
      S_MUL_LO: state_nxt = S_MUL_HI;
      S_MUL_HI: state_nxt = S_SCALE;
      S_MUL_A:  state_nxt = S_MUL_B;
      S_MUL_B:  state_nxt = S_SUB2;
      S_SUB2:   state_nxt = (prod_r >= pos_r) ? S_DONE : S_SCALE;
      S_SCALE:  state_nxt = S_DIVQ;
      S_DIVQ:   state_nxt = S_DIVQ_W;
      S_DIVQ_W: if (div_done) state_nxt = S_DONE;
      S_DONE:   if (emit) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_cfg_r <= '0;
      gain_r     <= GAIN_RST;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        code_cfg_r <= cfg_bus.integration_code;
      end
      if (in_fire) begin
        gain_r <= gain_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    rom_q_r <= pow_rom[idx_r];
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ch0_r    <= in_bus.full_spectrum_count;
          ch1_r    <= in_bus.infrared_count;
          code_r   <= code_in;
          used_r   <= gain_r;
          status_r <= retry ? ST_RETRY : (sat ? ST_SAT : ST_OK);
          lux_r    <= '0;
        end
      end
      S_SEG: begin
        div_num_r <= DIVN_W'({ch1_r, 16'b0});
        div_den_r <= DIVD_W'(ch0_r);
        if (23'd100 * {7'b0, ch1_r} <= 23'd61 * {7'b0, ch0_r}) begin
          seg_r <= SEG_TWO;
        end else if (19'd5 * {3'b0, ch1_r} <= 19'd4 * {3'b0, ch0_r}) begin
          seg_r <= SEG_THREE;
        end else begin
          seg_r <= SEG_FOUR;
        end
      end
      S_DIVR_W: begin
        if (div_done) begin
          idx_r <= div_quo[15 -: POW_TABLE_BITS];
        end
      end
      S_MUL_BP: prod_r <= mul_p;
      S_SUB1:   t_r    <= 36'(pos1 - prod_r);
      S_MUL_LO: acc_r  <= NUM_W'(mul_p);
      S_MUL_HI: acc_r  <= acc_r + {mul_p[33:0], 18'b0};
      S_MUL_A:  pos_r  <= mul_p;
      S_MUL_B:  prod_r <= mul_p;
      S_SUB2:   acc_r  <= {diff2[35:0], 16'b0};
      S_SCALE: begin
        div_num_r <= scaled[60:24];
        div_den_r <= den_of(code_r, used_r);
      end
      S_DIVQ_W: begin
        if (div_done) begin
          lux_r <= (|div_quo[DIVN_W-1:32]) ? '1 : div_quo[31:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_status_r <= status_r;
      o_lux_r    <= lux_r;
      o_used_r   <= used_r;
      o_next_r   <= gain_r;
    end
  end

  lslag_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num_r),
    .den   (div_den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_bus.valid     = out_valid_r;
  assign out_bus.status    = o_status_r;
  assign out_bus.lux_value = o_lux_r;
  assign out_bus.gain_used = o_used_r;
  assign out_bus.gain_next = o_next_r;

  a_retry_no_lux : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_status_r == ST_RETRY |-> o_lux_r == '0 && o_next_r == o_used_r - 2'd1)
    else $error("retry beat carries lux or wrong gain");

  a_gain_step : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> gain_r == $past(gain_r) || gain_r == $past(gain_r) + 2'd1 ||
                gain_r == $past(gain_r) - 2'd1)
    else $error("gain moved by more than one level");

  a_div_done_wait : assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIVR_W || state_r == S_DIVQ_W)
    else $error("divider finished outside a wait state");

  a_gain_held : assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |=> $stable(gain_r))
    else $error("gain changed while a reading is in work");

endmodule

`default_nettype wire

[sim/light_sensor_lux_autogain_core_tb.sv]
// ----------------------------------------------------------------------------
// light_sensor_lux_autogain_core_tb
// Drives readings and integration settings into the lux core, predicts every
// result (status, lux, gain before and after) and compares beat by beat.
// ----------------------------------------------------------------------------
`default_nettype none

module light_sensor_lux_autogain_core_tb
  import lslag_pkg::*;
;

  localparam int PTB       = 10;
  localparam int WD_LIMIT  = 20000;
  localparam int N_RANDOM  = 450;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] lux;
    logic [1:0]  gain_used;
    logic [1:0]  gain_next;
  } lux_res_t;

  typedef struct {
    logic [15:0] ch0;
    logic [15:0] ch1;
    logic        known;   // expected result typed in
    lux_res_t    res;
  } reading_row_t;

  logic clk;
  logic rst_n;

  lslag_in_if  in_bus ();
  lslag_out_if out_bus ();
  lslag_cfg_if cfg_bus ();

  light_sensor_lux_autogain_core #(.POW_TABLE_BITS(PTB)) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus.sink),
    .out_bus (out_bus.source),
    .cfg_bus (cfg_bus.sink)
  );

  // predictor state
  logic [2:0] pm_code;
  logic [1:0] pm_gain;
  lux_res_t   lux_expected_q[$];

  int errors;
  int n_in;
  int n_out;
  int n_retry;
  int n_satlow;
  int idle_cycles;
  int send_gap_pct;
  int stall_pct;
  logic [15:0] pow_rom [0:(1<<PTB)-1];

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // fifth root in Q0.12, then (i/2^B)^1.4 in Q0.16
  function automatic logic [15:0] pow_term(input int unsigned idx);
    longint unsigned tgt;
    longint unsigned y;
    longint unsigned c;
    tgt = (longint'(idx) * idx) << (60 - 2 * PTB);
    y = 0;
    for (int b = 12; b >= 0; b--) begin
      c = y | (64'd1 << b);
      if (c <= 4096 && c * c * c * c * c <= tgt) y = c;
    end
    return 16'((longint'(idx) * y * 16) >> PTB);
  endfunction

  function automatic logic [31:0] lux_of(input logic [15:0] c0, input logic [15:0] c1,
                                         input logic [2:0] code, input logic [1:0] g);
    longint unsigned a0, a1, pos, neg, den, r;
    logic [127:0] q;
    longint unsigned gf;
    a0 = c0;
    a1 = c1;
    if (a0 == 0) return '0;
    if (2 * a1 <= a0) begin
      r = (a1 << 16) / a0;
      pos = (64'd510027 * a0) << 16;
      neg = 64'd1040187 * a0 * pow_rom[r >> (16 - PTB)];
    end else if (100 * a1 <= 61 * a0) begin
      pos = (64'd375810 * a0) << 16;
      neg = (64'd520094 * a1) << 16;
    end else if (5 * a1 <= 4 * a0) begin
      pos = (64'd214748 * a0) << 16;
      neg = (64'd256691 * a1) << 16;
    end else if (10 * a1 <= 13 * a0) begin
      pos = (64'd24495 * a0) << 16;
      neg = (64'd18790 * a1) << 16;
    end else begin
      return '0;
    end
    if (neg >= pos) return '0;
    case (g)
      2'd0:    gf = 1;
      2'd1:    gf = 25;
      2'd2:    gf = 400;
      default: gf = 9900;
    endcase
    den = ((longint'(code) + 1) * 100 * gf) << 24;
    q = (128'(pos - neg) * 408) / den;
    return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  function automatic lux_res_t predict_reading(input logic [15:0] c0, input logic [15:0] c1);
    lux_res_t   r;
    logic [2:0] code;
    logic       sat;
    code = (pm_code > CODE_MAX) ? 3'd0 : pm_code;
    sat  = (code == 3'd0) ? (c0 >= SAT_SHORT || c1 >= SAT_SHORT)
                          : (c0 >= SAT_LONG || c1 >= SAT_LONG);
    r.gain_used = pm_gain;
    if (sat && pm_gain != 2'd0) begin
      pm_gain  = pm_gain - 2'd1;
      r.status = ST_RETRY;
      r.lux    = '0;
    end else begin
      r.status = sat ? ST_SAT : ST_OK;
      r.lux    = lux_of(c0, c1, code, pm_gain);
      if (c0 < LOW_SIGNAL && pm_gain < GAIN_MAX) pm_gain = pm_gain + 2'd1;
    end
    r.gain_next = pm_gain;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch on beat %0d: %s got %0d want %0d", n_out, what, got, want);
  endtask

  // result side: random stall, check each beat against the oldest expectation
  always @(posedge clk) begin
    lux_res_t e;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (lux_expected_q.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          e = lux_expected_q.pop_front();
          if (out_bus.status !== e.status)
            report_mismatch("status", out_bus.status, e.status);
          if (out_bus.lux_value !== e.lux)
            report_mismatch("lux_value", out_bus.lux_value, e.lux);
          if (out_bus.gain_used !== e.gain_used)
            report_mismatch("gain_used", out_bus.gain_used, e.gain_used);
          if (out_bus.gain_next !== e.gain_next)
            report_mismatch("gain_next", out_bus.gain_next, e.gain_next);
          if (e.status == ST_RETRY) n_retry++;
          if (e.status == ST_SAT) n_satlow++;
        end
        n_out++;
      end
      out_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", lux_expected_q.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic write_code(input logic [2:0] code);
    cfg_bus.valid            <= 1'b1;
    cfg_bus.integration_code <= code;
    do @(posedge clk); while (!cfg_bus.ready);
    pm_code = code;
    cfg_bus.valid <= 1'b0;
  endtask

  // valid stays up from one beat to the next unless the sender idles
  task automatic send_reading(input logic [15:0] c0, input logic [15:0] c1,
                              input logic known, input lux_res_t want);
    lux_res_t p;
    if ($urandom_range(99) < send_gap_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_bus.valid               <= 1'b1;
    in_bus.full_spectrum_count <= c0;
    in_bus.infrared_count      <= c1;
    do @(posedge clk); while (!in_bus.ready);
    p = predict_reading(c0, c1);
    if (known && p !== want)
      report_mismatch("predictor against table row", p, want);
    lux_expected_q.push_back(known ? want : p);
    n_in++;
  endtask

  task automatic drain;
    in_bus.valid <= 1'b0;
    while (lux_expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic lux_res_t rr(input logic [1:0] s, input logic [31:0] l,
                                  input logic [1:0] gu, input logic [1:0] gn);
    lux_res_t r;
    r.status = s; r.lux = l; r.gain_used = gu; r.gain_next = gn;
    return r;
  endfunction

  // random reading: plausible ratios in just under half the cases, the rest extremes and noise
  task automatic random_reading;
    logic [15:0] c0, c1;
    int k;
    k = $urandom_range(99);
    if (k < 45) begin
      c0 = 16'($urandom_range(36000, 1));
      c1 = 16'((longint'(c0) * $urandom_range(140)) / 100);
    end else if (k < 60) begin
      c0 = 16'($urandom_range(150));
      c1 = 16'($urandom_range(150));
    end else if (k < 75) begin
      c0 = 16'($urandom_range(65535, 36000));
      c1 = 16'($urandom);
    end else begin
      c0 = 16'($urandom);
      c1 = 16'($urandom);
    end
    send_reading(c0, c1, 1'b0, '0);
  endtask

  reading_row_t dir_tab[$];
  logic [2:0]   codes[$];

  initial begin
    for (int i = 0; i < (1 << PTB); i++) pow_rom[i] = pow_term(i);
    errors = 0; n_in = 0; n_out = 0; n_retry = 0; n_satlow = 0; idle_cycles = 0;
    send_gap_pct = 0; stall_pct = 0;
    pm_code = 3'd0; pm_gain = GAIN_RST;
    rst_n = 1'b0;
    in_bus.valid = 1'b0; in_bus.full_spectrum_count = '0; in_bus.infrared_count = '0;
    cfg_bus.valid = 1'b0; cfg_bus.integration_code = '0;
    out_bus.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, reset state gain 1, code 0
    dir_tab = '{
      '{16'd0,     16'd0,     1'b1, rr(ST_OK,    0, 2'd1, 2'd2)},
      '{16'd0,     16'hFFFF,  1'b1, rr(ST_RETRY, 0, 2'd2, 2'd1)},
      '{16'd36863, 16'd0,     1'b1, rr(ST_RETRY, 0, 2'd1, 2'd0)},
      '{16'd36863, 16'd100,   1'b0, '0},
      '{16'd0,     16'd36863, 1'b1, rr(ST_SAT,   0, 2'd0, 2'd1)},
      '{16'd36862, 16'd0,     1'b0, '0},
      '{16'd1000,  16'd500,   1'b0, '0},
      '{16'd1000,  16'd610,   1'b0, '0},
      '{16'd1000,  16'd611,   1'b0, '0},
      '{16'd1000,  16'd800,   1'b0, '0},
      '{16'd1000,  16'd1300,  1'b0, '0},
      '{16'd1000,  16'd1301,  1'b1, rr(ST_OK,    0, 2'd1, 2'd1)},
      '{16'd99,    16'd10,    1'b0, '0},
      '{16'd99,    16'd99,    1'b0, '0},
      '{16'd5,     16'd0,     1'b0, '0},
      '{16'd100,   16'd0,     1'b0, '0},
      '{16'd65535, 16'd65535, 1'b0, '0},
      '{16'd65535, 16'd65535, 1'b0, '0},
      '{16'd65535, 16'd65535, 1'b0, '0},
      '{16'd65535, 16'd0,     1'b0, '0},
      '{16'd36000, 16'd1,     1'b0, '0},
      '{16'h5555,  16'h2AAA,  1'b0, '0}
    };
    foreach (dir_tab[i])
      send_reading(dir_tab[i].ch0, dir_tab[i].ch1, dir_tab[i].known, dir_tab[i].res);
    drain();

    // random part: idling phases cycled across the integration settings, extremes first
    codes = '{3'd5, 3'd0, 3'd7, 3'd2, 3'd6, 3'd1, 3'd3, 3'd4};
    foreach (codes[p]) begin
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 80; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 80; end
        default: begin send_gap_pct = 22; stall_pct = 22; end
      endcase
      write_code(codes[p]);
      repeat (N_RANDOM / codes.size()) random_reading();
      drain();
    end

    $display("%0d readings over 8 integration settings and 4 idling mixes", n_in);
    $display("%0d results checked, %0d retries, %0d saturated at lowest gain",
             n_out, n_retry, n_satlow);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hw/rtl/lslag_pkg.sv
hw/rtl/lslag_if.sv
hw/rtl/lslag_div.sv
hw/rtl/light_sensor_lux_autogain_core.sv
sim/light_sensor_lux_autogain_core_tb.sv
